>>> hdl/rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangular/polar converter
// Fixed-point formats, CORDIC angle table and the item that moves down the
// pipeline.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Datapath width for x and y (Q.20, with headroom for the CORDIC gain).
  localparam int XW = 27;
  // Angle width (Q.24, holds a Q4.12 angle shifted left by 12).
  localparam int ZW = 28;
  // Gain constant width (signed) and product width.
  localparam int GW = 25;
  localparam int PW = XW + GW;
  // Rounded value width before saturation.
  localparam int RW = 21;
  // Number of entries in the arctangent table.
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 28'sd105414357;
  localparam logic signed [GW-1:0] GAIN_Q24    = 25'sd10188014;
  localparam logic signed [RW-1:0] OUT_MAX     = 21'sd65535;
  localparam logic signed [RW-1:0] OUT_MIN     = -21'sd65536;

  typedef enum logic {
    CMD_TO_POLAR = 1'b0,
    CMD_TO_RECT  = 1'b1
  } rpc_cmd_t;

  // One item in flight through the CORDIC stages.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 vec;   // vectoring (cartesian to polar)
    logic                 flip;  // negate both results at the end
    logic                 zero;  // zero vector, results forced to zero
  } rpc_item_t;

  // atan(2^-idx) in Q.24, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/rect_polar_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_polar_converter_top: CORDIC rectangular/polar converter
// Converts one complex Q4.12 number per transfer between cartesian and polar
// form and returns the pair as Q5.12, saturated to 17 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid, in_stall, in_command, in_operand_a, in_operand_b.
//   in_command 0 turns (real, imaginary) into (magnitude, angle); 1 turns
//   (magnitude, angle) into (real, imaginary). Angles are radians.
//   Result channel: out_valid, out_stall, out_result_a, out_result_b.
//   Every input transfer gives exactly one result transfer, in order.
//   The pipeline has two stages of angle reduction and setup, one stage per
//   micro-rotation, then gain multiply, rounding and saturation stages.
//   Throughput is one transfer per cycle while out_stall is low; each
//   stage holds its own valid bit.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling until the pipeline is full; only then is
//   in_stall raised. Nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline; no result is pending
//   afterwards.
// ----------------------------------------------------------------------------
module rect_polar_converter_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic signed [15:0]  in_operand_a,
  input  logic signed [15:0]  in_operand_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  out_result_a,
  output logic signed [16:0]  out_result_b
);

  localparam int STEPS = (CORDIC_STEPS < rpc_pkg::ATAN_ENTRIES) ?
                         CORDIC_STEPS : rpc_pkg::ATAN_ENTRIES;

  logic [STEPS:0]     cv;
  logic [STEPS:0]     cr;
  rpc_pkg::rpc_item_t ci [STEPS+1];
  logic               pre_ready;

  assign in_stall = !pre_ready;

  rpc_pre u_pre (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_command   (in_command),
    .up_operand_a (in_operand_a),
    .up_operand_b (in_operand_b),
    .up_ready     (pre_ready),
    .dn_valid     (cv[0]),
    .dn_item      (ci[0]),
    .dn_ready     (cr[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    rpc_cordic_stage #(
      .STEP (g)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[g]),
      .up_item  (ci[g]),
      .up_ready (cr[g]),
      .dn_valid (cv[g+1]),
      .dn_item  (ci[g+1]),
      .dn_ready (cr[g+1])
    );
  end

  rpc_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (cv[STEPS]),
    .up_item     (ci[STEPS]),
    .up_ready    (cr[STEPS]),
    .dn_valid    (out_valid),
    .dn_result_a (out_result_a),
    .dn_result_b (out_result_b),
    .dn_ready    (!out_stall)
  );

endmodule

>>> hdl/rpc_pre.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pre: input conditioning
// Two register stages: angle range reduction, then quadrant folding and the
// starting vector for the CORDIC stages.
// ----------------------------------------------------------------------------
module rpc_pre (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  logic                 up_command,
  input  logic signed [15:0]   up_operand_a,
  input  logic signed [15:0]   up_operand_b,
  output logic                 up_ready,
  output logic                 dn_valid,
  output rpc_pkg::rpc_item_t   dn_item,
  input  logic                 dn_ready
);

  logic                        v1_r;
  logic                        cmd1_r, cmd1_nxt;
  logic signed [15:0]          a1_r;
  logic                        zero1_r, zero1_nxt;
  logic                        bneg1_r;
  logic signed [rpc_pkg::ZW-1:0] z1_r, z1_nxt;
  logic signed [rpc_pkg::ZW-1:0] zb;
  logic                        en1, en2;

  logic                        v2_r;
  rpc_pkg::rpc_item_t          item2_r, item2_nxt;
  logic signed [rpc_pkg::XW-1:0] xa;
  logic signed [rpc_pkg::XW-1:0] yb;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;
  assign dn_item  = item2_r;

  // Stage 1: a rotation angle is brought into -pi..pi. One correction is
  // enough for any Q4.12 input, since 8 rad lies below 3*pi. In vectoring
  // mode the imaginary part passes through unchanged.
  assign zb = {up_operand_b, 12'd0};

  always_comb begin
    cmd1_nxt  = up_command;
    zero1_nxt = (up_operand_a == 16'sd0) && (up_operand_b == 16'sd0);
    if (up_command == rpc_pkg::CMD_TO_RECT && zb > rpc_pkg::ANG_PI) begin
      z1_nxt = zb - rpc_pkg::ANG_TWO_PI;
    end else if (up_command == rpc_pkg::CMD_TO_RECT && zb < -rpc_pkg::ANG_PI) begin
      z1_nxt = zb + rpc_pkg::ANG_TWO_PI;
    end else begin
      z1_nxt = zb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r  <= cmd1_nxt;
      a1_r    <= up_operand_a;
      bneg1_r <= up_operand_b[15];
      zero1_r <= zero1_nxt;
      z1_r    <= z1_nxt;
    end
  end

  // Stage 2: starting vector. The angle register of stage 1 holds b << 12,
  // so b << 8 is recovered from it for the vectoring case.
  assign xa = {{3{a1_r[15]}}, a1_r, 8'd0};
  assign yb = {{3{bneg1_r}}, z1_r[27:4]};

  always_comb begin
    item2_nxt      = '0;
    item2_nxt.zero = 1'b0;
    item2_nxt.flip = 1'b0;
    if (cmd1_r == rpc_pkg::CMD_TO_POLAR) begin
      item2_nxt.vec  = 1'b1;
      item2_nxt.zero = zero1_r;
      if (a1_r < 16'sd0) begin
        // Left half plane: negate the vector and start from +-pi.
        item2_nxt.x = -xa;
        item2_nxt.y = -yb;
        item2_nxt.z = bneg1_r ? -rpc_pkg::ANG_PI : rpc_pkg::ANG_PI;
      end else begin
        item2_nxt.x = xa;
        item2_nxt.y = yb;
        item2_nxt.z = '0;
      end
    end else begin
      item2_nxt.vec = 1'b0;
      item2_nxt.x   = xa;
      item2_nxt.y   = '0;
      if (z1_r > rpc_pkg::ANG_HALF_PI) begin
        item2_nxt.z    = z1_r - rpc_pkg::ANG_PI;
        item2_nxt.flip = 1'b1;
      end else if (z1_r < -rpc_pkg::ANG_HALF_PI) begin
        item2_nxt.z    = z1_r + rpc_pkg::ANG_PI;
        item2_nxt.flip = 1'b1;
      end else begin
        item2_nxt.z = z1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      item2_r <= item2_nxt;
    end
  end

endmodule

>>> hdl/rpc_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cordic_stage: one CORDIC micro-rotation
// Rotates or vectors by atan(2^-STEP) and registers the result.
// ----------------------------------------------------------------------------
module rpc_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  rpc_pkg::rpc_item_t up_item,
  output logic               up_ready,
  output logic               dn_valid,
  output rpc_pkg::rpc_item_t dn_item,
  input  logic               dn_ready
);

  logic                          v_r;
  rpc_pkg::rpc_item_t            item_r, item_nxt;
  logic signed [rpc_pkg::XW-1:0] xs, ys;
  logic signed [rpc_pkg::ZW-1:0] ang;
  logic                          ccw;
  logic                          en;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_item  = item_r;

  assign xs  = $signed(up_item.x) >>> STEP;
  assign ys  = $signed(up_item.y) >>> STEP;
  assign ang = rpc_pkg::atan_q24(5'(STEP));

  // Vectoring drives y toward zero; rotation drives z toward zero.
  assign ccw = up_item.vec ? up_item.y[rpc_pkg::XW-1] : !up_item.z[rpc_pkg::ZW-1];

  always_comb begin
    item_nxt = up_item;
    if (ccw) begin
      item_nxt.x = $signed(up_item.x) - ys;
      item_nxt.y = $signed(up_item.y) + xs;
      item_nxt.z = $signed(up_item.z) - ang;
    end else begin
      item_nxt.x = $signed(up_item.x) + ys;
      item_nxt.y = $signed(up_item.y) - xs;
      item_nxt.z = $signed(up_item.z) + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> hdl/rpc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_post: gain correction and output formatting
// Three register stages: gain multiply, rounding with sign flip and zero
// forcing, saturation into the output register.
// ----------------------------------------------------------------------------
module rpc_post (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  rpc_pkg::rpc_item_t   up_item,
  output logic                 up_ready,
  output logic                 dn_valid,
  output logic signed [16:0]   dn_result_a,
  output logic signed [16:0]   dn_result_b,
  input  logic                 dn_ready
);

  localparam logic signed [rpc_pkg::PW-1:0] ROUND_P = rpc_pkg::PW'(64'sd2147483648);
  localparam logic signed [rpc_pkg::ZW-1:0] ROUND_Z = rpc_pkg::ZW'(32'sd2048);

  logic en1, en2, en3;

  // Stage 1: products
  logic                          v1_r;
  logic signed [rpc_pkg::PW-1:0] px1_r, px1_nxt, py1_r, py1_nxt;
  logic signed [rpc_pkg::ZW-1:0] z1_r;
  logic                          vec1_r, flip1_r, zero1_r;

  // Stage 2: rounded values
  logic                          v2_r;
  logic signed [rpc_pkg::RW-1:0] ra2_r, ra2_nxt, rb2_r, rb2_nxt;
  logic signed [rpc_pkg::PW-1:0] px_rnd, py_rnd;
  logic signed [rpc_pkg::ZW-1:0] z_rnd;

  // Stage 3: saturated output register
  logic                          v3_r;
  logic signed [16:0]            ra3_r, ra3_nxt, rb3_r, rb3_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v3_r;
  assign dn_result_a = ra3_r;
  assign dn_result_b = rb3_r;

  assign px1_nxt = $signed(up_item.x) * rpc_pkg::GAIN_Q24;
  assign py1_nxt = $signed(up_item.y) * rpc_pkg::GAIN_Q24;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1_r   <= px1_nxt;
      py1_r   <= py1_nxt;
      z1_r    <= up_item.z;
      vec1_r  <= up_item.vec;
      flip1_r <= up_item.flip;
      zero1_r <= up_item.zero;
    end
  end

  // Round half up: add half an LSB, then take the upper bits.
  assign px_rnd = px1_r + ROUND_P;
  assign py_rnd = py1_r + ROUND_P;
  assign z_rnd  = z1_r + ROUND_Z;

  always_comb begin
    ra2_nxt = {px_rnd[rpc_pkg::PW-1], px_rnd[rpc_pkg::PW-1:32]};
    if (vec1_r) begin
      rb2_nxt = {{(rpc_pkg::RW-16){z_rnd[rpc_pkg::ZW-1]}}, z_rnd[rpc_pkg::ZW-1:12]};
    end else begin
      rb2_nxt = {py_rnd[rpc_pkg::PW-1], py_rnd[rpc_pkg::PW-1:32]};
    end
    if (flip1_r) begin
      ra2_nxt = -ra2_nxt;
      rb2_nxt = -rb2_nxt;
    end
    if (zero1_r) begin
      ra2_nxt = '0;
      rb2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ra2_r <= ra2_nxt;
      rb2_r <= rb2_nxt;
    end
  end

  always_comb begin
    if (ra2_r > rpc_pkg::OUT_MAX) begin
      ra3_nxt = rpc_pkg::OUT_MAX[16:0];
    end else if (ra2_r < rpc_pkg::OUT_MIN) begin
      ra3_nxt = rpc_pkg::OUT_MIN[16:0];
    end else begin
      ra3_nxt = ra2_r[16:0];
    end
    if (rb2_r > rpc_pkg::OUT_MAX) begin
      rb3_nxt = rpc_pkg::OUT_MAX[16:0];
    end else if (rb2_r < rpc_pkg::OUT_MIN) begin
      rb3_nxt = rpc_pkg::OUT_MIN[16:0];
    end else begin
      rb3_nxt = rb2_r[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      ra3_r <= ra3_nxt;
      rb3_r <= rb3_nxt;
    end
  end

endmodule

>>> dv/rpc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_checker: result predictor and scoreboard for the rect/polar converter
// Watches both channels. Every input transfer is converted in software with
// the same fixed-point CORDIC steps. Each result transfer is compared field by
// field against the oldest pending conversion.
// ----------------------------------------------------------------------------
module rpc_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic signed [15:0] in_operand_a,
  input  logic signed [15:0] in_operand_b,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [16:0] out_result_a,
  input  logic signed [16:0] out_result_b,
  input  logic               end_of_test,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct {
    rpc_pkg::rpc_cmd_t  cmd;
    logic signed [15:0] op_a;
    logic signed [15:0] op_b;
    logic signed [16:0] res_a;
    logic signed [16:0] res_b;
  } conversion_t;

  // atan(2^-i) in Q.24, rounded to nearest.
  longint atan_q24_tbl [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2
  };

  conversion_t pending_q [$];
  conversion_t oldest;
  bit          end_checked;

  // Q.20 value times the CORDIC gain, rounded half up to Q.12.
  function automatic longint apply_gain(input longint v);
    return (v * longint'(rpc_pkg::GAIN_Q24) + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic logic signed [16:0] clip17(input longint v);
    if (v > longint'(rpc_pkg::OUT_MAX)) return 17'(rpc_pkg::OUT_MAX);
    if (v < longint'(rpc_pkg::OUT_MIN)) return 17'(rpc_pkg::OUT_MIN);
    return 17'(v);
  endfunction

  function automatic conversion_t convert_pair(input rpc_pkg::rpc_cmd_t cmd,
                                               input logic signed [15:0] op_a,
                                               input logic signed [15:0] op_b);
    conversion_t c;
    longint      x, y, z, nx, ny, ra, rb;
    bit          flip;
    c.cmd  = cmd;
    c.op_a = op_a;
    c.op_b = op_b;
    flip   = 1'b0;
    if (cmd == rpc_pkg::CMD_TO_POLAR) begin
      if (op_a == 0 && op_b == 0) begin
        c.res_a = '0;
        c.res_b = '0;
        return c;
      end
      x = longint'(op_a) * 256;
      y = longint'(op_b) * 256;
      z = 0;
      // Left half plane: fold the vector over and start the angle at +-pi.
      if (op_a < 0) begin
        z = (op_b >= 0) ? longint'(rpc_pkg::ANG_PI) : -longint'(rpc_pkg::ANG_PI);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + atan_q24_tbl[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - atan_q24_tbl[i];
        end
        x = nx;
        y = ny;
      end
      ra = apply_gain(x);
      rb = (z + 2048) >>> 12;
    end else begin
      z = longint'(op_b) * 4096;
      while (z > longint'(rpc_pkg::ANG_PI)) z = z - longint'(rpc_pkg::ANG_TWO_PI);
      while (z < -longint'(rpc_pkg::ANG_PI)) z = z + longint'(rpc_pkg::ANG_TWO_PI);
      // Beyond a quarter turn, rotate by pi and negate the results instead.
      if (z > longint'(rpc_pkg::ANG_HALF_PI)) begin
        z    = z - longint'(rpc_pkg::ANG_PI);
        flip = 1'b1;
      end else if (z < -longint'(rpc_pkg::ANG_HALF_PI)) begin
        z    = z + longint'(rpc_pkg::ANG_PI);
        flip = 1'b1;
      end
      x = longint'(op_a) * 256;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - atan_q24_tbl[i];
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + atan_q24_tbl[i];
        end
        x = nx;
        y = ny;
      end
      ra = apply_gain(x);
      rb = apply_gain(y);
      if (flip) begin
        ra = -ra;
        rb = -rb;
      end
    end
    c.res_a = clip17(ra);
    c.res_b = clip17(rb);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_q.delete();
      fail_count  = 0;
      end_checked = 1'b0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall)
        pending_q.push_back(convert_pair(rpc_pkg::rpc_cmd_t'(in_command),
                                         in_operand_a, in_operand_b));
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer: a=%0d b=%0d",
                                    out_result_a, out_result_b));
        end else begin
          oldest = pending_q.pop_front();
          if (out_result_a !== oldest.res_a)
            report_mismatch($sformatf("result_a cmd=%0d a=%0d b=%0d: got %0d, want %0d",
                                      oldest.cmd, oldest.op_a, oldest.op_b,
                                      out_result_a, oldest.res_a));
          if (out_result_b !== oldest.res_b)
            report_mismatch($sformatf("result_b cmd=%0d a=%0d b=%0d: got %0d, want %0d",
                                      oldest.cmd, oldest.op_a, oldest.op_b,
                                      out_result_b, oldest.res_b));
        end
      end
      if (end_of_test && !end_checked) begin
        end_checked = 1'b1;
        if (pending_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", pending_q.size()));
      end
      outstanding <= pending_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the CORDIC rectangular/polar converter
// Sends directed corner cases in both directions, then random conversions
// under three idle patterns and one long output hold-off. The checker
// predicts and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STEPS         = 16;
  localparam int LATENCY       = STEPS + 5;
  localparam int ITEMS_PER_RUN = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic               in_command   = 1'b0;
  logic signed [15:0] in_operand_a = '0;
  logic signed [15:0] in_operand_b = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic signed [16:0] out_result_a;
  logic signed [16:0] out_result_b;
  logic               end_of_test  = 1'b0;
  int                 fail_count;
  int                 outstanding;

  int send_idle_pct = 10;
  int recv_idle_pct = 82;
  int phase         = 1;

  rect_polar_converter_top #(.CORDIC_STEPS(STEPS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result_a (out_result_a),
    .out_result_b (out_result_b)
  );

  rpc_checker #(.CORDIC_STEPS(STEPS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result_a (out_result_a),
    .out_result_b (out_result_b),
    .end_of_test  (end_of_test),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Presents one conversion and returns at the edge where it transfers.
  task automatic send_pair(input rpc_pkg::rpc_cmd_t cmd,
                           input logic signed [15:0] op_a,
                           input logic signed [15:0] op_b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= op_a;
    in_operand_b <= op_b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [15:0] random_operand();
    case ($urandom_range(3))
      0, 1:    return 16'($urandom);
      2:       return 16'($urandom_range(8192) - 4096);
      default: begin
        case ($urandom_range(4))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sd0;
          3:       return 16'sd1;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++)
      send_pair(rpc_pkg::rpc_cmd_t'($urandom_range(1)), random_operand(),
                random_operand());
  endtask

  // Receiver: random stalls, plus one long hold-off at the start of the last run.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 3 && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cartesian to polar: zero vector, axes, left half plane on both sides.
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sd0, 16'sd0);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sh7fff, 16'sd0);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sh8000, 16'sd0);
    send_pair(rpc_pkg::CMD_TO_POLAR, -16'sd1, 16'sd0);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sd0, 16'sh7fff);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sd0, 16'sh8000);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sh7fff, 16'sh7fff);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sh8000, 16'sh8000);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sh8000, 16'sh7fff);
    send_pair(rpc_pkg::CMD_TO_POLAR, -16'sd4096, -16'sd1);
    send_pair(rpc_pkg::CMD_TO_POLAR, 16'sd1, -16'sd1);
    // Polar to cartesian: quadrant folding, wrap past pi, negative magnitude.
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, 16'sd0);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, 16'sd6434);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, 16'sd6500);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, -16'sd6500);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, 16'sd12868);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, -16'sd12868);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd4096, 16'sd25736);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sh7fff, 16'sh7fff);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sh7fff, 16'sh8000);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sh8000, 16'sh8000);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sh8000, 16'sd6434);
    send_pair(rpc_pkg::CMD_TO_RECT, 16'sd0, 16'sd1234);

    send_random(ITEMS_PER_RUN);

    send_idle_pct = 82;
    recv_idle_pct = 10;
    phase         = 2;
    send_random(ITEMS_PER_RUN);

    // Last run idles on neither side, so the hold-off backs the pipeline up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase         = 3;
    send_random(ITEMS_PER_RUN);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
hdl/rpc_pkg.sv
hdl/rpc_pre.sv
hdl/rpc_cordic_stage.sv
hdl/rpc_post.sv
hdl/rect_polar_converter_top.sv
dv/rpc_checker.sv
dv/testbench.sv
